FILE: sv/rbdc_pkg.sv
// rbdc_pkg: shared types, constants and helpers of the display converter
// no dependencies; imported by every module of the block
package rbdc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NCH       = 4;
    localparam int CH_W      = 32;
    localparam int CNT_W     = 16;
    localparam int MID_W     = 16;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;

    // offset into the depth range and the range itself
    localparam int DEP_W = CH_W + 2;
    // jet segment terms, up to four times an offset
    localparam int JET_W = DEP_W + 3;
    // position product
    localparam int POS_W = 2 * CH_W;

    // dividend and divisor widths of the byte divider
    localparam int NUM_W = (2 * FRAC_BITS + 10 > JET_W + 9) ? 2 * FRAC_BITS + 10 : JET_W + 9;
    localparam int DEN_A = (CNT_W + FRAC_BITS + 1 > 2 * FRAC_BITS + 1) ?
                           CNT_W + FRAC_BITS + 1 : 2 * FRAC_BITS + 1;
    localparam int DEN_W = (DEN_A > DEP_W) ? DEN_A : DEP_W;
    localparam int QBITS = BYTE_W;

    // accept to strobe: two operand stages, one range check, eight quotient bits
    localparam int PIPE_LAT = 3 + QBITS;

    localparam logic signed [NUM_W-1:0] ONE_N    = NUM_W'(1) << FRAC_BITS;
    localparam logic signed [POS_W-1:0] POS_FULL = POS_W'(1) << (2 * FRAC_BITS);
    localparam logic [BYTE_W-1:0] BYTE_MAX  = 8'd255;
    localparam logic [BYTE_W-1:0] BYTE_GREY = 8'd63;

    typedef enum logic [2:0] {
        MODE_COLOUR   = 3'd0,
        MODE_NORMAL   = 3'd1,
        MODE_POSITION = 3'd2,
        MODE_DEPTH    = 3'd3,
        MODE_TEXCOORD = 3'd4,
        MODE_VARY     = 3'd5,
        MODE_VCOLOUR  = 3'd6,
        MODE_MATERIAL = 3'd7
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE      = 3'd0,
        REG_POS_SCALE = 3'd1,
        REG_BOUND_A   = 3'd2,
        REG_BOUND_B   = 3'd3,
        REG_FALSE_COL = 3'd4
    } t_reg;

    typedef struct packed {
        t_mode             mode;
        logic [CH_W-1:0]   pos_scale;
        logic [CH_W-1:0]   bound_a;
        logic [CH_W-1:0]   bound_b;
        logic              false_col;
    } t_cfg;

    // one channel's division job: forced byte or floor(num/den) clamped
    typedef struct packed {
        logic                force_en;
        logic [BYTE_W-1:0]   fval;
        logic [NUM_W-1:0]    num;
        logic [DEN_W-1:0]    den;
    } t_op;

    // material colours: red, blue, green, magenta, cyan, yellow, white, grey
    localparam logic [0:7][0:2][BYTE_W-1:0] MAT_TABLE = '{
        '{8'd255, 8'd0,   8'd0  }, '{8'd0,   8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd0  }, '{8'd255, 8'd0,   8'd255},
        '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd255, 8'd0  },
        '{8'd255, 8'd255, 8'd255}, '{8'd127, 8'd127, 8'd127}};

    // times 255 as shift and subtract
    function automatic logic signed [NUM_W-1:0] mul255(input logic signed [NUM_W-1:0] v);
        logic signed [NUM_W-1:0] s;
        s = v <<< 8;
        return s - v;
    endfunction

endpackage

FILE: sv/rbdc_front.sv
// rbdc_front: operand stages, position product and per-mode dividend/divisor
// depends on rbdc_pkg
module rbdc_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_vld,
    input  logic        [rbdc_pkg::CH_W-1:0]     i_chan [rbdc_pkg::NCH],
    input  logic        [rbdc_pkg::CNT_W-1:0]    i_cnt,
    input  logic        [rbdc_pkg::MID_W-1:0]    i_mid,
    input  rbdc_pkg::t_cfg                       i_cfg,
    output logic                                 o_vld,
    output rbdc_pkg::t_op                        o_op [rbdc_pkg::NCH]
);
    import rbdc_pkg::*;

    logic signed [CH_W-1:0]  lo, hi, ba, bb;
    logic signed [DEP_W-1:0] dif, d_rng;

    logic                    r_a_vld;
    logic signed [CH_W-1:0]  r_x   [NCH];
    logic signed [POS_W-1:0] r_p   [NCH];
    logic signed [DEP_W-1:0] r_n   [NCH];
    logic [CNT_W-1:0]        r_cnt;
    logic [MID_W-1:0]        r_mid;

    t_op                     n_op  [NCH];
    t_op                     r_op  [NCH];
    logic                    r_b_vld;

    // depth range from the two bounds, at least one lsb
    always_comb begin
        ba  = $signed(i_cfg.bound_a);
        bb  = $signed(i_cfg.bound_b);
        lo  = (ba < bb) ? ba : bb;
        hi  = (ba < bb) ? bb : ba;
        dif = DEP_W'(hi) - DEP_W'(lo);
        d_rng = (dif < DEP_W'(1)) ? DEP_W'(1) : dif;
    end

    // stage a: capture pixel, position product, depth offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_vld;
        end
        for (int c = 0; c < NCH; c++) begin
            r_x[c] <= $signed(i_chan[c]);
            r_p[c] <= POS_W'($signed(i_chan[c])) * POS_W'($signed(i_cfg.pos_scale));
            r_n[c] <= DEP_W'($signed(i_chan[c])) - DEP_W'(lo);
        end
        r_cnt <= i_cnt;
        r_mid <= i_mid;
    end

    // stage b: per-mode division job for each channel
    always_comb begin
        logic signed [NUM_W-1:0] xe;
        logic signed [JET_W-1:0] n4, n2, d1, d2, d3, d4;
        for (int c = 0; c < NCH; c++) begin
            xe = NUM_W'(r_x[c]);
            n4 = JET_W'(r_n[c]) <<< 2;
            n2 = JET_W'(r_n[c]) <<< 1;
            d1 = JET_W'(d_rng);
            d2 = d1 <<< 1;
            d3 = d2 + d1;
            d4 = d1 <<< 2;
            n_op[c].force_en = 1'b0;
            n_op[c].fval     = '0;
            n_op[c].num      = mul255(xe);
            n_op[c].den      = DEN_W'(1) << FRAC_BITS;
            case (i_cfg.mode)
                MODE_COLOUR: begin
                    if (r_cnt != '0) begin
                        n_op[c].den = DEN_W'(r_cnt) << FRAC_BITS;
                    end
                end
                MODE_NORMAL: begin
                    n_op[c].num = mul255(xe + ONE_N);
                    n_op[c].den = DEN_W'(2) << FRAC_BITS;
                end
                MODE_POSITION: begin
                    n_op[c].den = DEN_W'(1) << (2 * FRAC_BITS);
                    if (r_p[c] <= POS_W'(0)) begin
                        n_op[c].force_en = 1'b1;
                    end else if (r_p[c] >= POS_FULL) begin
                        n_op[c].force_en = 1'b1;
                        n_op[c].fval     = BYTE_MAX;
                    end else begin
                        n_op[c].num = mul255(r_p[c][NUM_W-1:0]);
                    end
                end
                MODE_DEPTH: begin
                    n_op[c].den = DEN_W'(d_rng);
                    n_op[c].num = mul255(NUM_W'(r_n[c]));
                    if (i_cfg.false_col) begin
                        if (c == 0) begin
                            if (n2 <= d1) begin
                                n_op[c].force_en = 1'b1;
                            end else if (n4 < d3) begin
                                n_op[c].num = mul255(NUM_W'(n4 - d2));
                            end else begin
                                n_op[c].force_en = 1'b1;
                                n_op[c].fval     = BYTE_MAX;
                            end
                        end else if (c == 1) begin
                            if (n4 <= d1) begin
                                n_op[c].num = mul255(NUM_W'(n4));
                            end else if (n4 < d3) begin
                                n_op[c].force_en = 1'b1;
                                n_op[c].fval     = BYTE_MAX;
                            end else begin
                                n_op[c].num = mul255(NUM_W'(d4 - n4));
                            end
                        end else if (c == 2) begin
                            if (n4 <= d1) begin
                                n_op[c].force_en = 1'b1;
                                n_op[c].fval     = BYTE_MAX;
                            end else if (n2 < d1) begin
                                n_op[c].num = mul255(NUM_W'(d2 - n4));
                            end else begin
                                n_op[c].force_en = 1'b1;
                            end
                        end else begin
                            n_op[c].force_en = 1'b1;
                            n_op[c].fval     = BYTE_MAX;
                        end
                    end
                end
                MODE_MATERIAL: begin
                    n_op[c].force_en = 1'b1;
                    if (c == NCH - 1) begin
                        n_op[c].fval = BYTE_MAX;
                    end else if (r_mid[MID_W-1]) begin
                        n_op[c].fval = BYTE_GREY;
                    end else begin
                        n_op[c].fval = MAT_TABLE[r_mid[2:0]][c];
                    end
                end
                default: begin
                    n_op[c].den = DEN_W'(1) << FRAC_BITS;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        for (int c = 0; c < NCH; c++) begin
            r_op[c] <= n_op[c];
        end
    end

    assign o_vld = r_b_vld;
    assign o_op  = r_op;

endmodule

FILE: sv/rbdc_div.sv
// rbdc_div: pipelined restoring divider giving clamped floor bytes, one bit a stage
// depends on rbdc_pkg
module rbdc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  rbdc_pkg::t_op                 i_op   [rbdc_pkg::NCH],
    output logic                          o_vld,
    output logic [rbdc_pkg::BYTE_W-1:0]   o_byte [rbdc_pkg::NCH]
);
    import rbdc_pkg::*;

    logic                r_vld  [QBITS+1];
    logic [NUM_W-1:0]    r_rem  [QBITS+1][NCH];
    logic [DEN_W-1:0]    r_den  [QBITS+1][NCH];
    logic [BYTE_W-1:0]   r_q    [QBITS+1][NCH];
    logic                r_done [QBITS+1][NCH];

    logic [NUM_W-1:0]    n_rem  [QBITS+1][NCH];
    logic [BYTE_W-1:0]   n_q    [QBITS+1][NCH];
    logic                n_done [QBITS+1][NCH];

    // entry: forced bytes, non-positive dividends and quotients past 255
    always_comb begin
        logic [NUM_W-1:0] lim;
        for (int c = 0; c < NCH; c++) begin
            lim          = NUM_W'(i_op[c].den) << QBITS;
            n_rem[0][c]  = i_op[c].num;
            n_q[0][c]    = '0;
            n_done[0][c] = 1'b1;
            if (i_op[c].force_en) begin
                n_q[0][c] = i_op[c].fval;
            end else if ($signed(i_op[c].num) <= 0) begin
                n_q[0][c] = '0;
            end else if (i_op[c].num >= lim) begin
                n_q[0][c] = BYTE_MAX;
            end else begin
                n_done[0][c] = 1'b0;
            end
        end
    end

    // quotient bit steps, most significant first
    always_comb begin
        logic [NUM_W-1:0] sh;
        for (int s = 1; s <= QBITS; s++) begin
            for (int c = 0; c < NCH; c++) begin
                sh           = NUM_W'(r_den[s-1][c]) << (QBITS - s);
                n_rem[s][c]  = r_rem[s-1][c];
                n_q[s][c]    = r_q[s-1][c];
                n_done[s][c] = r_done[s-1][c];
                if (!r_done[s-1][c] && (r_rem[s-1][c] >= sh)) begin
                    n_rem[s][c]          = r_rem[s-1][c] - sh;
                    n_q[s][c][QBITS - s] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= QBITS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_vld;
            for (int s = 1; s <= QBITS; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
        for (int c = 0; c < NCH; c++) begin
            r_den[0][c] <= i_op[c].den;
        end
        for (int s = 1; s <= QBITS; s++) begin
            for (int c = 0; c < NCH; c++) begin
                r_den[s][c] <= r_den[s-1][c];
            end
        end
        for (int s = 0; s <= QBITS; s++) begin
            for (int c = 0; c < NCH; c++) begin
                r_rem[s][c]  <= n_rem[s][c];
                r_q[s][c]    <= n_q[s][c];
                r_done[s][c] <= n_done[s][c];
            end
        end
    end

    assign o_vld = r_vld[QBITS];
    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            o_byte[c] = r_q[QBITS][c];
        end
    end

endmodule

FILE: sv/render_buffer_display_convert.sv
// render_buffer_display_convert: top level, configuration registers and pipeline
// depends on rbdc_pkg, rbdc_front, rbdc_div
//
//   channel   handshake               payload
//   pixel in  i_start / o_busy        i_chan_*, i_sample_count, i_material_id
//   result    o_strobe (no stall)     o_out_red, o_out_green, o_out_blue, o_out_alpha
//   config    i_cfg_valid/o_cfg_ready i_cfg_index, i_cfg_data
//
// one pixel a cycle; each result passes, after its beat is taken, through
// two operand stages (one 32x32 product), a range check and eight quotient-bit
// stages of the divider. o_busy stays low and o_cfg_ready high.
// reset clears the valid bits and loads the register defaults; results are
// never held back, the receiver takes each on its strobe cycle.
module render_buffer_display_convert (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic        [rbdc_pkg::CH_W-1:0]   i_chan_red,
    input  logic        [rbdc_pkg::CH_W-1:0]   i_chan_green,
    input  logic        [rbdc_pkg::CH_W-1:0]   i_chan_blue,
    input  logic        [rbdc_pkg::CH_W-1:0]   i_chan_alpha,
    input  logic        [rbdc_pkg::CNT_W-1:0]  i_sample_count,
    input  logic        [rbdc_pkg::MID_W-1:0]  i_material_id,
    output logic                               o_strobe,
    output logic        [rbdc_pkg::BYTE_W-1:0] o_out_red,
    output logic        [rbdc_pkg::BYTE_W-1:0] o_out_green,
    output logic        [rbdc_pkg::BYTE_W-1:0] o_out_blue,
    output logic        [rbdc_pkg::BYTE_W-1:0] o_out_alpha,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rbdc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rbdc_pkg::CFG_W-1:0]         i_cfg_data
);
    import rbdc_pkg::*;

    t_cfg               r_cfg;
    logic               accept;
    logic [CH_W-1:0]    chan [NCH];
    logic               op_vld;
    t_op                op   [NCH];
    logic [BYTE_W-1:0]  bytes [NCH];

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = i_start && !o_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode      <= MODE_COLOUR;
            r_cfg.pos_scale <= CH_W'(1) << FRAC_BITS;
            r_cfg.bound_a   <= '0;
            r_cfg.bound_b   <= CH_W'(10) << FRAC_BITS;
            r_cfg.false_col <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_MODE:      r_cfg.mode      <= t_mode'(i_cfg_data[2:0]);
                REG_POS_SCALE: r_cfg.pos_scale <= i_cfg_data;
                REG_BOUND_A:   r_cfg.bound_a   <= i_cfg_data;
                REG_BOUND_B:   r_cfg.bound_b   <= i_cfg_data;
                REG_FALSE_COL: r_cfg.false_col <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign chan[0] = i_chan_red;
    assign chan[1] = i_chan_green;
    assign chan[2] = i_chan_blue;
    assign chan[3] = i_chan_alpha;

    rbdc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (accept),
        .i_chan  (chan),
        .i_cnt   (i_sample_count),
        .i_mid   (i_material_id),
        .i_cfg   (r_cfg),
        .o_vld   (op_vld),
        .o_op    (op)
    );

    rbdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (op_vld),
        .i_op    (op),
        .o_vld   (o_strobe),
        .o_byte  (bytes)
    );

    assign o_out_red   = bytes[0];
    assign o_out_green = bytes[1];
    assign o_out_blue  = bytes[2];
    assign o_out_alpha = bytes[3];

    // every strobe comes from an accepted input beat
    a_strobe_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, PIPE_LAT))
        else $error("result strobe without matching input beat");

    // reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("result strobe right after reset");

endmodule
